@@ design/vcsg_pkg.sv @@
package vcsg_pkg;

    // Field and register widths
    localparam int ADC_W    = 12;
    localparam int DAC_W    = 12;
    localparam int CLK_W    = 27;
    localparam int FREQ_W   = 14;
    localparam int RELOAD_W = 27;
    localparam int SUM_W    = 28;
    localparam int CNT_W    = 16;
    localparam int AVG_W    = 12;
    localparam int HZ_W     = 15;
    localparam int ROM_IDX_W = 6;
    localparam int ROM_DEPTH = 40;

    // Shared divider: widest dividend is the window sum, widest divisor is
    // frequency times a table length of up to 64.
    localparam int DIVIDEND_W = 28;
    localparam int DIVISOR_W  = 22;
    localparam int STEP_W     = $clog2(DIVIDEND_W);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 27;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HZ       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_FREQ       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_SPAN      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_RELOAD = 2'd3;

    // Register reset values
    localparam logic [CLK_W-1:0]    CLOCK_HZ_RST       = 27'd80000000;
    localparam logic [FREQ_W-1:0]   MIN_FREQ_RST       = 14'd100;
    localparam logic [FREQ_W-1:0]   FREQ_SPAN_RST      = 14'd900;
    localparam logic [RELOAD_W-1:0] INITIAL_RELOAD_RST = 27'd20000;

    // Request actions
    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_UPDATE = 2'd1;
    localparam logic [1:0] ACT_TICK   = 2'd2;

    // Result kinds
    localparam logic KIND_RELOAD = 1'b0;
    localparam logic KIND_DAC    = 1'b1;

    localparam logic [DIVISOR_W-1:0] ADC_FULL_SCALE = 22'd4095;
    localparam logic [RELOAD_W-1:0]  RELOAD_MAX     = 27'h7FFFFFF;

    typedef struct packed {
        logic [1:0]       action;
        logic [ADC_W-1:0] adc_value;
    } vcsg_cmd_t;

    typedef struct packed {
        logic                kind;
        logic [DAC_W-1:0]    sample;
        logic                first_frame;
        logic [RELOAD_W-1:0] reload;
    } vcsg_res_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

    // One sine period of DAC codes; entries past the table read as zero.
    function automatic logic [DAC_W-1:0] sine_code(input logic [ROM_IDX_W-1:0] idx);
        logic [DAC_W-1:0] code;
        case (idx)
            6'd0:  code = 12'd500;
            6'd1:  code = 12'd578;
            6'd2:  code = 12'd655;
            6'd3:  code = 12'd727;
            6'd4:  code = 12'd794;
            6'd5:  code = 12'd854;
            6'd6:  code = 12'd905;
            6'd7:  code = 12'd946;
            6'd8:  code = 12'd976;
            6'd9:  code = 12'd994;
            6'd10: code = 12'd1000;
            6'd11: code = 12'd994;
            6'd12: code = 12'd976;
            6'd13: code = 12'd946;
            6'd14: code = 12'd905;
            6'd15: code = 12'd854;
            6'd16: code = 12'd794;
            6'd17: code = 12'd727;
            6'd18: code = 12'd655;
            6'd19: code = 12'd578;
            6'd20: code = 12'd500;
            6'd21: code = 12'd422;
            6'd22: code = 12'd345;
            6'd23: code = 12'd273;
            6'd24: code = 12'd206;
            6'd25: code = 12'd146;
            6'd26: code = 12'd95;
            6'd27: code = 12'd54;
            6'd28: code = 12'd24;
            6'd29: code = 12'd6;
            6'd30: code = 12'd0;
            6'd31: code = 12'd6;
            6'd32: code = 12'd24;
            6'd33: code = 12'd54;
            6'd34: code = 12'd95;
            6'd35: code = 12'd146;
            6'd36: code = 12'd206;
            6'd37: code = 12'd273;
            6'd38: code = 12'd345;
            6'd39: code = 12'd422;
            default: code = 12'd0;
        endcase
        return code;
    endfunction

endpackage

@@ design/vcsg_div.sv @@
module vcsg_div (
    input  logic               clk,
    input  logic               rst_n,
    input  vcsg_pkg::div_req_t req,
    output vcsg_pkg::div_rsp_t rsp
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [vcsg_pkg::STEP_W-1:0]     step_reg;
    logic [vcsg_pkg::DIVISOR_W-1:0]  divisor_reg;
    logic [vcsg_pkg::DIVISOR_W-1:0]  rem_reg;
    logic [vcsg_pkg::DIVIDEND_W-1:0] quo_reg;

    logic [vcsg_pkg::DIVISOR_W:0]    trial;
    logic                            fits;
    logic [vcsg_pkg::DIVISOR_W-1:0]  rem_next;
    logic [vcsg_pkg::DIVIDEND_W-1:0] quo_next;

    // Restoring division, one quotient bit per cycle; dividend bits shift
    // out of the top of the quotient register as quotient bits enter below.
    assign trial    = {rem_reg, quo_reg[vcsg_pkg::DIVIDEND_W-1]};
    assign fits     = trial >= {1'b0, divisor_reg};
    assign rem_next = fits ? vcsg_pkg::DIVISOR_W'(trial - {1'b0, divisor_reg})
                           : trial[vcsg_pkg::DIVISOR_W-1:0];
    assign quo_next = {quo_reg[vcsg_pkg::DIVIDEND_W-2:0], fits};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= vcsg_pkg::STEP_W'(vcsg_pkg::DIVIDEND_W - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            divisor_reg <= req.divisor;
            rem_reg     <= '0;
            quo_reg     <= req.dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ design/voltage_controlled_sine_generator.sv @@
// Sample and tick requests are accepted back to back while the result output is free.
// A tick that expires the countdown shows its DAC result the cycle after acceptance.
// An update request makes up to three passes through the shared 28-step radix-2 divider before its
// reload result; an empty window skips the first pass and a zero divisor the last.
// Reset (asynchronous, active low): registers return to defaults, window and table index clear,
// countdown and reload load 20000, no result pending.
module voltage_controlled_sine_generator #(
    parameter int TABLE_LEN   = 40,
    parameter int MAX_SAMPLES = 65535
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_ready,
    input  vcsg_pkg::vcsg_cmd_t                 cmd,
    output logic                                res_valid,
    input  logic                                res_ready,
    output vcsg_pkg::vcsg_res_t                 res,
    input  logic                                cfg_write,
    input  logic [vcsg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vcsg_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int IDX_W = (TABLE_LEN > 1) ? $clog2(TABLE_LEN) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_AVG  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_SPAN = 3'd3;
    localparam logic [2:0] S_DEN  = 3'd4;
    localparam logic [2:0] S_CLK  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [vcsg_pkg::CLK_W-1:0]      clock_hz_reg, clock_hz_next;
    logic [vcsg_pkg::FREQ_W-1:0]     min_freq_reg, min_freq_next;
    logic [vcsg_pkg::FREQ_W-1:0]     freq_span_reg, freq_span_next;
    logic [vcsg_pkg::RELOAD_W-1:0]   init_reload_reg, init_reload_next;

    logic [vcsg_pkg::SUM_W-1:0]      sum_reg, sum_next;
    logic [vcsg_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [vcsg_pkg::RELOAD_W-1:0]   reload_reg, reload_next;
    logic [vcsg_pkg::RELOAD_W-1:0]   countdown_reg, countdown_next;
    logic [IDX_W-1:0]                idx_reg, idx_next;
    logic                            started_reg, started_next;
    logic [2:0]                      state_reg, state_next;
    logic                            go_reg, go_next;
    logic                            res_valid_reg, res_valid_next;

    logic [vcsg_pkg::DIVIDEND_W-1:0] dividend_reg, dividend_next;
    logic [vcsg_pkg::DIVISOR_W-1:0]  divisor_reg, divisor_next;
    logic [vcsg_pkg::AVG_W-1:0]      avg_reg, avg_next;
    logic [vcsg_pkg::HZ_W-1:0]       freq_reg, freq_next;
    logic [vcsg_pkg::RELOAD_W-1:0]   new_reload_reg, new_reload_next;
    vcsg_pkg::vcsg_res_t             res_reg, res_next;

    vcsg_pkg::div_req_t              div_req;
    vcsg_pkg::div_rsp_t              div_rsp;

    logic [vcsg_pkg::DIVISOR_W-1:0]  denom;
    logic [IDX_W:0]                  idx_inc;
    logic                            res_free;
    logic                            cmd_take;

    assign res_free  = !res_valid_reg || res_ready;
    assign cmd_ready = (state_reg == S_IDLE) && res_free;
    assign cmd_take  = cmd_valid && cmd_ready;
    assign denom     = vcsg_pkg::DIVISOR_W'(freq_reg) * vcsg_pkg::DIVISOR_W'(TABLE_LEN);
    assign idx_inc   = (IDX_W + 1)'(idx_reg) + (IDX_W + 1)'(1);

    assign div_req.start    = go_reg;
    assign div_req.dividend = dividend_reg;
    assign div_req.divisor  = divisor_reg;

    vcsg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        clock_hz_next    = clock_hz_reg;
        min_freq_next    = min_freq_reg;
        freq_span_next   = freq_span_reg;
        init_reload_next = init_reload_reg;
        sum_next         = sum_reg;
        count_next       = count_reg;
        reload_next      = reload_reg;
        countdown_next   = countdown_reg;
        idx_next         = idx_reg;
        started_next     = started_reg;
        state_next       = state_reg;
        go_next          = 1'b0;
        res_valid_next   = res_valid_reg && !res_ready;
        dividend_next    = dividend_reg;
        divisor_next     = divisor_reg;
        avg_next         = avg_reg;
        freq_next        = freq_reg;
        new_reload_next  = new_reload_reg;
        res_next         = res_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_take)
                begin
                    case (cmd.action)
                        vcsg_pkg::ACT_SAMPLE:
                        begin
                            // Drop samples once the window is full
                            if (count_reg < vcsg_pkg::CNT_W'(MAX_SAMPLES))
                            begin
                                sum_next   = sum_reg + vcsg_pkg::SUM_W'(cmd.adc_value);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        vcsg_pkg::ACT_UPDATE:
                        begin
                            dividend_next = sum_reg;
                            divisor_next  = vcsg_pkg::DIVISOR_W'(count_reg);
                            sum_next      = '0;
                            count_next    = '0;
                            if (count_reg == '0)
                            begin
                                avg_next   = '0;
                                state_next = S_MUL;
                            end
                            else
                            begin
                                go_next    = 1'b1;
                                state_next = S_AVG;
                            end
                        end
                        vcsg_pkg::ACT_TICK:
                        begin
                            if (countdown_reg == '0)
                            begin
                                countdown_next       = reload_reg;
                                res_valid_next       = 1'b1;
                                res_next.kind        = vcsg_pkg::KIND_DAC;
                                res_next.sample      =
                                    vcsg_pkg::sine_code(vcsg_pkg::ROM_IDX_W'(idx_reg));
                                res_next.first_frame = !started_reg;
                                res_next.reload      = '0;
                                started_next         = 1'b1;
                                idx_next = (idx_inc >= (IDX_W + 1)'(TABLE_LEN))
                                           ? '0 : idx_inc[IDX_W-1:0];
                            end
                            else
                            begin
                                countdown_next = countdown_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_AVG:
            begin
                if (div_rsp.done)
                begin
                    avg_next   = div_rsp.quotient[vcsg_pkg::AVG_W-1:0];
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                dividend_next = vcsg_pkg::DIVIDEND_W'(avg_reg)
                              * vcsg_pkg::DIVIDEND_W'(freq_span_reg);
                divisor_next  = vcsg_pkg::ADC_FULL_SCALE;
                go_next       = 1'b1;
                state_next    = S_SPAN;
            end
            S_SPAN:
            begin
                if (div_rsp.done)
                begin
                    freq_next  = vcsg_pkg::HZ_W'(min_freq_reg)
                               + div_rsp.quotient[vcsg_pkg::HZ_W-1:0];
                    state_next = S_DEN;
                end
            end
            S_DEN:
            begin
                // Saturate the reload when the step rate comes out zero
                if (denom == '0)
                begin
                    new_reload_next = vcsg_pkg::RELOAD_MAX;
                    state_next      = S_DONE;
                end
                else
                begin
                    dividend_next = vcsg_pkg::DIVIDEND_W'(clock_hz_reg);
                    divisor_next  = denom;
                    go_next       = 1'b1;
                    state_next    = S_CLK;
                end
            end
            S_CLK:
            begin
                if (div_rsp.done)
                begin
                    new_reload_next = div_rsp.quotient[vcsg_pkg::RELOAD_W-1:0];
                    state_next      = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_free)
                begin
                    reload_next          = new_reload_reg;
                    countdown_next       = new_reload_reg;
                    res_valid_next       = 1'b1;
                    res_next.kind        = vcsg_pkg::KIND_RELOAD;
                    res_next.sample      = '0;
                    res_next.first_frame = 1'b0;
                    res_next.reload      = new_reload_reg;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_write)
        begin
            case (cfg_index)
                vcsg_pkg::REG_CLOCK_HZ:
                begin
                    clock_hz_next = cfg_data[vcsg_pkg::CLK_W-1:0];
                end
                vcsg_pkg::REG_MIN_FREQ:
                begin
                    min_freq_next = cfg_data[vcsg_pkg::FREQ_W-1:0];
                end
                vcsg_pkg::REG_FREQ_SPAN:
                begin
                    freq_span_next = cfg_data[vcsg_pkg::FREQ_W-1:0];
                end
                vcsg_pkg::REG_INITIAL_RELOAD:
                begin
                    // Also load the running timer, like a timer load register
                    init_reload_next = cfg_data[vcsg_pkg::RELOAD_W-1:0];
                    reload_next      = cfg_data[vcsg_pkg::RELOAD_W-1:0];
                    countdown_next   = cfg_data[vcsg_pkg::RELOAD_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hz_reg    <= vcsg_pkg::CLOCK_HZ_RST;
            min_freq_reg    <= vcsg_pkg::MIN_FREQ_RST;
            freq_span_reg   <= vcsg_pkg::FREQ_SPAN_RST;
            init_reload_reg <= vcsg_pkg::INITIAL_RELOAD_RST;
            sum_reg         <= '0;
            count_reg       <= '0;
            reload_reg      <= vcsg_pkg::INITIAL_RELOAD_RST;
            countdown_reg   <= vcsg_pkg::INITIAL_RELOAD_RST;
            idx_reg         <= '0;
            started_reg     <= 1'b0;
            state_reg       <= S_IDLE;
            go_reg          <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            clock_hz_reg    <= clock_hz_next;
            min_freq_reg    <= min_freq_next;
            freq_span_reg   <= freq_span_next;
            init_reload_reg <= init_reload_next;
            sum_reg         <= sum_next;
            count_reg       <= count_next;
            reload_reg      <= reload_next;
            countdown_reg   <= countdown_next;
            idx_reg         <= idx_next;
            started_reg     <= started_next;
            state_reg       <= state_next;
            go_reg          <= go_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dividend_reg   <= dividend_next;
        divisor_reg    <= divisor_next;
        avg_reg        <= avg_next;
        freq_reg       <= freq_next;
        new_reload_reg <= new_reload_next;
        res_reg        <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_update_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_take && cmd.action == vcsg_pkg::ACT_UPDATE) |=> !cmd_ready)
        else $error("update request did not block further requests");

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_AVG || state_reg == S_SPAN || state_reg == S_CLK))
        else $error("divider finished while sequencer was not waiting");

    a_index_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (IDX_W + 1)'(idx_reg) < (IDX_W + 1)'(TABLE_LEN))
        else $error("table index past table length");

    a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= vcsg_pkg::CNT_W'(MAX_SAMPLES))
        else $error("sample window count past limit");

endmodule

@@ tb/voltage_controlled_sine_generator_test.sv @@
`timescale 1ns / 100ps

module voltage_controlled_sine_generator_test;

    // Table length and window limit of the generator as delivered
    localparam int TABLE_LEN     = 40;
    localparam int MAX_SAMPLES   = 65535;
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASE_ITEMS   = 200;
    localparam int LONG_WINDOW   = 96;

    // Action code the block must ignore
    localparam logic [1:0] ACT_NONE = 2'd3;

    // One sine period, entry 0 in the low bits
    localparam logic [vcsg_pkg::ROM_DEPTH*vcsg_pkg::DAC_W-1:0] SINE_CODES = {
        12'd422, 12'd345, 12'd273, 12'd206, 12'd146, 12'd95,  12'd54,   12'd24,
        12'd6,   12'd0,   12'd6,   12'd24,  12'd54,  12'd95,  12'd146,  12'd206,
        12'd273, 12'd345, 12'd422, 12'd500, 12'd578, 12'd655, 12'd727,  12'd794,
        12'd854, 12'd905, 12'd946, 12'd976, 12'd994, 12'd1000, 12'd994, 12'd976,
        12'd946, 12'd905, 12'd854, 12'd794, 12'd727, 12'd655, 12'd578,  12'd500
    };

    logic                            clk;
    logic                            rst_n;
    logic                            cmd_valid;
    logic                            cmd_ready;
    vcsg_pkg::vcsg_cmd_t             cmd;
    logic                            res_valid;
    logic                            res_ready;
    vcsg_pkg::vcsg_res_t             res;
    logic                            cfg_write;
    logic [vcsg_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [vcsg_pkg::CFG_DATA_W-1:0] cfg_data;

    // Shadow of the generator
    logic [vcsg_pkg::CLK_W-1:0]     cfg_clock_hz;
    logic [vcsg_pkg::FREQ_W-1:0]    cfg_min_freq;
    logic [vcsg_pkg::FREQ_W-1:0]    cfg_freq_span;
    logic [vcsg_pkg::SUM_W-1:0]     win_sum;
    logic [vcsg_pkg::CNT_W-1:0]     win_count;
    logic [vcsg_pkg::RELOAD_W-1:0]  step_reload;
    logic [vcsg_pkg::RELOAD_W-1:0]  step_count;
    logic [vcsg_pkg::ROM_IDX_W-1:0] phase_idx;
    logic                           dac_started;

    vcsg_pkg::vcsg_res_t pending_results[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int requests_sent  = 0;
    int reload_results = 0;
    int dac_results    = 0;
    int cycle_count    = 0;

    voltage_controlled_sine_generator #(
        .TABLE_LEN   (TABLE_LEN),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void advance_generator(input vcsg_pkg::vcsg_cmd_t rq);
        logic [63:0] avg;
        logic [63:0] freq;
        logic [63:0] denom;
        logic [63:0] quot;
        vcsg_pkg::vcsg_res_t r;
        r = '0;
        case (rq.action)
            vcsg_pkg::ACT_SAMPLE:
            begin
                // a full window drops further samples
                if (win_count < MAX_SAMPLES)
                begin
                    win_sum   = win_sum + rq.adc_value;
                    win_count = win_count + 1'b1;
                end
            end
            vcsg_pkg::ACT_UPDATE:
            begin
                avg   = (win_count != 0) ? 64'(win_sum) / 64'(win_count) : 64'd0;
                freq  = 64'(cfg_min_freq) + (avg * 64'(cfg_freq_span)) / 64'd4095;
                denom = freq * 64'(TABLE_LEN);
                // zero frequency saturates the reload
                quot  = (denom != 0) ? 64'(cfg_clock_hz) / denom : 64'(vcsg_pkg::RELOAD_MAX);
                r.kind      = vcsg_pkg::KIND_RELOAD;
                r.reload    = quot[vcsg_pkg::RELOAD_W-1:0];
                win_sum     = '0;
                win_count   = '0;
                step_reload = r.reload;
                step_count  = r.reload;
                pending_results.push_back(r);
            end
            vcsg_pkg::ACT_TICK:
            begin
                if (step_count != 0)
                    step_count = step_count - 1'b1;
                else
                begin
                    step_count    = step_reload;
                    r.kind        = vcsg_pkg::KIND_DAC;
                    r.sample      = (phase_idx < vcsg_pkg::ROM_DEPTH) ?
                                    SINE_CODES[phase_idx*vcsg_pkg::DAC_W +: vcsg_pkg::DAC_W]
                                    : '0;
                    r.first_frame = !dac_started;
                    dac_started   = 1'b1;
                    phase_idx     = (phase_idx + 1 >= TABLE_LEN) ? '0 : phase_idx + 1'b1;
                    pending_results.push_back(r);
                end
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("%0t: %s mismatch, got 0x%0h expected 0x%0h", $time, what, got, want);
    endtask

    task automatic check_result(input vcsg_pkg::vcsg_res_t got);
        vcsg_pkg::vcsg_res_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch("unexpected result", 64'(got), 64'd0);
            return;
        end
        want = pending_results.pop_front();
        if (got.kind !== want.kind)
            report_mismatch("kind", 64'(got.kind), 64'(want.kind));
        if (got.sample !== want.sample)
            report_mismatch("sample", 64'(got.sample), 64'(want.sample));
        if (got.first_frame !== want.first_frame)
            report_mismatch("first_frame", 64'(got.first_frame), 64'(want.first_frame));
        if (got.reload !== want.reload)
            report_mismatch("reload", 64'(got.reload), 64'(want.reload));
        if (want.kind == vcsg_pkg::KIND_RELOAD)
            reload_results++;
        else
            dac_results++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            check_result(res);
        res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("voltage_controlled_sine_generator_test NOT OK");
            $finish;
        end
    end

    // Returns at the edge that accepted the request, with valid still high
    task automatic send_request(input logic [1:0] act,
                                input logic [vcsg_pkg::ADC_W-1:0] adc);
        vcsg_pkg::vcsg_cmd_t rq;
        rq.action    = act;
        rq.adc_value = adc;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= rq;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        advance_generator(rq);
        requests_sent++;
    endtask

    task automatic wait_idle();
        cmd_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // let any sample or tick still in flight finish
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [vcsg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [vcsg_pkg::CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            vcsg_pkg::REG_CLOCK_HZ:  cfg_clock_hz  = data[vcsg_pkg::CLK_W-1:0];
            vcsg_pkg::REG_MIN_FREQ:  cfg_min_freq  = data[vcsg_pkg::FREQ_W-1:0];
            vcsg_pkg::REG_FREQ_SPAN: cfg_freq_span = data[vcsg_pkg::FREQ_W-1:0];
            vcsg_pkg::REG_INITIAL_RELOAD:
            begin
                // the write also restarts the countdown
                step_reload = data[vcsg_pkg::RELOAD_W-1:0];
                step_count  = data[vcsg_pkg::RELOAD_W-1:0];
            end
            default: ;
        endcase
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_setting(input logic [vcsg_pkg::CFG_DATA_W-1:0] clock_hz,
                                 input logic [vcsg_pkg::CFG_DATA_W-1:0] min_freq,
                                 input logic [vcsg_pkg::CFG_DATA_W-1:0] freq_span,
                                 input logic [vcsg_pkg::CFG_DATA_W-1:0] init_reload);
        write_reg(vcsg_pkg::REG_CLOCK_HZ, clock_hz);
        write_reg(vcsg_pkg::REG_MIN_FREQ, min_freq);
        write_reg(vcsg_pkg::REG_FREQ_SPAN, freq_span);
        write_reg(vcsg_pkg::REG_INITIAL_RELOAD, init_reload);
    endtask

    task automatic test_directed();
        // reset registers first: window with extreme codes, ignored action, empty window
        send_request(vcsg_pkg::ACT_SAMPLE, 12'hFFF);
        send_request(vcsg_pkg::ACT_SAMPLE, 12'h000);
        send_request(vcsg_pkg::ACT_SAMPLE, 12'hAAA);
        send_request(vcsg_pkg::ACT_SAMPLE, 12'h555);
        send_request(ACT_NONE, 12'hFFF);
        send_request(vcsg_pkg::ACT_TICK, 12'hABC);
        send_request(vcsg_pkg::ACT_UPDATE, 12'h5A5);
        send_request(vcsg_pkg::ACT_UPDATE, 12'h000);
        wait_idle();
        write_reg(vcsg_pkg::REG_CLOCK_HZ, 27'd20000);
        write_reg(vcsg_pkg::REG_INITIAL_RELOAD, 27'd1);
        repeat (6)
            send_request(vcsg_pkg::ACT_TICK, vcsg_pkg::ADC_W'($urandom_range(4095)));
        // full-scale average drives the reload to zero: every tick emits
        send_request(vcsg_pkg::ACT_SAMPLE, 12'hFFF);
        send_request(vcsg_pkg::ACT_UPDATE, 12'h000);
        repeat (6)
            send_request(vcsg_pkg::ACT_TICK, vcsg_pkg::ADC_W'($urandom_range(4095)));
        wait_idle();
    endtask

    task automatic test_long_window();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_setting(27'd100000000, 27'd10000, 27'd10000, 27'd0);
        repeat (LONG_WINDOW)
            send_request(vcsg_pkg::ACT_SAMPLE, 12'hFFF);
        // a couple of low codes pull the average just under full scale
        repeat (2)
            send_request(vcsg_pkg::ACT_SAMPLE, 12'h000);
        send_request(vcsg_pkg::ACT_UPDATE, 12'h000);
        send_request(vcsg_pkg::ACT_SAMPLE, 12'd7);
        send_request(vcsg_pkg::ACT_UPDATE, 12'h000);
        wait_idle();
    endtask

    task automatic test_zero_frequency();
        write_reg(vcsg_pkg::REG_MIN_FREQ, 27'd0);
        send_request(vcsg_pkg::ACT_UPDATE, 12'h000);
        send_request(vcsg_pkg::ACT_TICK, 12'h000);
        wait_idle();
        write_reg(vcsg_pkg::REG_FREQ_SPAN, 27'd0);
        repeat (3)
            send_request(vcsg_pkg::ACT_SAMPLE, 12'hFFF);
        send_request(vcsg_pkg::ACT_UPDATE, 12'hFFF);
        wait_idle();
        write_reg(vcsg_pkg::REG_INITIAL_RELOAD, 27'd2);
        repeat (4)
            send_request(vcsg_pkg::ACT_TICK, 12'hFFF);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int         pick;
        logic [1:0] act;
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 80;
                    // zero reload: every tick emits, walks the whole table and wraps
                    write_setting(27'd1, 27'd1, 27'd0, 27'd0);
                end
                1:
                begin
                    send_idle_pct  = 80;
                    recv_stall_pct = 0;
                    write_setting(vcsg_pkg::CFG_DATA_W'($urandom_range(300000, 1000)),
                                  vcsg_pkg::CFG_DATA_W'($urandom_range(2000, 1)),
                                  vcsg_pkg::CFG_DATA_W'($urandom_range(10000)),
                                  vcsg_pkg::CFG_DATA_W'($urandom_range(30)));
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    write_setting(27'd100000000, 27'd10000, 27'd10000, 27'd100000000);
                end
                3:
                begin
                    send_idle_pct  = 25;
                    recv_stall_pct = 25;
                    // upper bits of the narrow registers must be dropped
                    write_setting(27'h7FFFFFF, 27'h7FFFFFF, 27'h7FFFFFF, 27'd5);
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    write_setting(vcsg_pkg::CFG_DATA_W'($urandom_range(50000, 1)),
                                  vcsg_pkg::CFG_DATA_W'($urandom_range(500, 1)),
                                  vcsg_pkg::CFG_DATA_W'($urandom_range(10000)),
                                  vcsg_pkg::CFG_DATA_W'($urandom_range(20)));
                end
            endcase
            repeat (PHASE_ITEMS)
            begin
                pick = $urandom_range(99);
                if (pick < 50)
                    act = vcsg_pkg::ACT_TICK;
                else if (pick < 85)
                    act = vcsg_pkg::ACT_SAMPLE;
                else if (pick < 96)
                    act = vcsg_pkg::ACT_UPDATE;
                else
                    act = ACT_NONE;
                send_request(act, vcsg_pkg::ADC_W'($urandom_range(4095)));
            end
            wait_idle();
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        res_ready <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;

        cfg_clock_hz  = vcsg_pkg::CLOCK_HZ_RST;
        cfg_min_freq  = vcsg_pkg::MIN_FREQ_RST;
        cfg_freq_span = vcsg_pkg::FREQ_SPAN_RST;
        win_sum       = '0;
        win_count     = '0;
        step_reload   = vcsg_pkg::INITIAL_RELOAD_RST;
        step_count    = vcsg_pkg::INITIAL_RELOAD_RST;
        phase_idx     = '0;
        dac_started   = 1'b0;

        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_long_window();
        test_zero_frequency();
        test_random_traffic();
        wait_idle();

        $display("Sent %0d requests (directed, long window, zero frequency, random phases)",
                 requests_sent);
        $display("Checked %0d reload and %0d DAC results, %0d mismatches",
                 reload_results, dac_results, mismatches);
        if (mismatches == 0)
            $display("voltage_controlled_sine_generator_test OK");
        else
            $display("voltage_controlled_sine_generator_test NOT OK");
        $finish;
    end

endmodule

@@ filelist.f @@
design/vcsg_pkg.sv
design/vcsg_div.sv
design/voltage_controlled_sine_generator.sv
tb/voltage_controlled_sine_generator_test.sv
